>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the sbus frame receiver RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ON(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sbfr assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sbfr forbidden condition seen");

`endif

>>> hw/rtl/sbfr_pkg.sv
// Package for the sbus frame receiver: frame layout constants and shared types.
// No dependencies.
`timescale 1ns / 1ps

package sbfr_pkg;

    localparam int BYTE_W        = 8;
    localparam int FRAME_BYTES   = 25;
    localparam int CHANNELS      = 16;
    localparam int POS_W         = 5;
    localparam int CH_W          = 4;
    localparam int VAL_W         = 11;
    localparam int BANK_SLOTS    = 32;
    localparam int RAM_DEPTH     = 2 * BANK_SLOTS;
    localparam int RAM_ADDR_W    = 6;
    localparam int ACC_W         = 18;
    localparam int ACC_CNT_W     = 5;
    localparam int CFG_IDX_W     = 1;

    // frame byte positions
    localparam logic [POS_W-1:0] PAYLOAD_FIRST = 5'd1;
    localparam logic [POS_W-1:0] PAYLOAD_LAST  = 5'd22;
    localparam logic [POS_W-1:0] FLAGS_POS     = 5'd23;
    localparam logic [POS_W-1:0] LAST_POS      = 5'(FRAME_BYTES - 1);

    // flags byte bits
    localparam int LOST_BIT     = 2;
    localparam int FAILSAFE_BIT = 3;

    localparam logic [CH_W-1:0]      LAST_CHANNEL = 4'(CHANNELS - 1);
    localparam logic [ACC_CNT_W-1:0] VAL_BITS     = 5'(VAL_W);
    localparam logic [ACC_CNT_W-1:0] BYTE_BITS    = 5'(BYTE_W);

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 1'd1;
    localparam logic [BYTE_W-1:0]    START_RESET      = 8'h0F;
    localparam logic [BYTE_W-1:0]    END_RESET        = 8'h00;

    // per-frame information handed from front to back
    typedef struct packed {
        logic lost;
        logic failsafe;
    } desc_t;

    // frame buffer write port driven by the front
    typedef struct packed {
        logic                  en;
        logic [RAM_ADDR_W-1:0] addr;
        logic [BYTE_W-1:0]     data;
    } ram_wr_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

endpackage

>>> hw/rtl/sbfr_front.sv
// Front of the sbus frame receiver: sync hunt, byte collection, marker check.
// Depends on sbfr_pkg; writes payload bytes into the back's frame buffer.
`timescale 1ns / 1ps

module sbfr_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic                             full,
    input  logic [sbfr_pkg::BYTE_W-1:0]      rx_byte,
    input  logic                             cfg_wr_en,
    input  logic [sbfr_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [sbfr_pkg::BYTE_W-1:0]      cfg_wdata,
    output sbfr_pkg::ram_wr_t                ram_wr,
    output logic                             desc_push,
    output sbfr_pkg::desc_t                  desc
);

    logic [sbfr_pkg::BYTE_W-1:0] start_marker_reg;
    logic [sbfr_pkg::BYTE_W-1:0] end_marker_reg;
    logic                        in_sync_reg, in_sync_next;
    logic [sbfr_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                        bank_reg, bank_next;
    logic [sbfr_pkg::BYTE_W-1:0] byte0_reg;
    logic                        lost_reg;
    logic                        failsafe_reg;
    logic                        accept;
    logic                        frame_end;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= sbfr_pkg::START_RESET;
            end_marker_reg   <= sbfr_pkg::END_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                sbfr_pkg::CFG_START_MARKER: start_marker_reg <= cfg_wdata;
                sbfr_pkg::CFG_END_MARKER:   end_marker_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign accept    = push && !full;
    assign frame_end = accept && in_sync_reg && (pos_reg == sbfr_pkg::LAST_POS);

    // sync and byte position tracking
    always_comb
    begin
        in_sync_next = in_sync_reg;
        pos_next     = pos_reg;
        bank_next    = bank_reg;
        if (accept)
        begin
            if (!in_sync_reg)
            begin
                if (rx_byte == start_marker_reg)
                begin
                    in_sync_next = 1'b1;
                    pos_next     = sbfr_pkg::PAYLOAD_FIRST;
                end
            end
            else if (frame_end)
            begin
                in_sync_next = 1'b0;
                pos_next     = '0;
                if (desc_push)
                    bank_next = !bank_reg;
            end
            else
            begin
                pos_next = pos_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sync_reg <= 1'b0;
            pos_reg     <= '0;
            bank_reg    <= 1'b0;
        end
        else
        begin
            in_sync_reg <= in_sync_next;
            pos_reg     <= pos_next;
            bank_reg    <= bank_next;
        end
    end

    // opening byte and flag bits are kept locally
    always_ff @(posedge clk)
    begin
        if (accept && !in_sync_reg && (rx_byte == start_marker_reg))
            byte0_reg <= rx_byte;
        if (accept && in_sync_reg && (pos_reg == sbfr_pkg::FLAGS_POS))
        begin
            lost_reg     <= rx_byte[sbfr_pkg::LOST_BIT];
            failsafe_reg <= rx_byte[sbfr_pkg::FAILSAFE_BIT];
        end
    end

    // payload bytes go to the current buffer bank
    always_comb
    begin
        ram_wr.en   = accept && in_sync_reg
                      && (pos_reg >= sbfr_pkg::PAYLOAD_FIRST)
                      && (pos_reg <= sbfr_pkg::PAYLOAD_LAST);
        ram_wr.addr = {bank_reg, pos_reg};
        ram_wr.data = rx_byte;
    end

    // a frame is handed on only when both markers match
    assign desc_push     = frame_end && (byte0_reg == start_marker_reg)
                           && (rx_byte == end_marker_reg);
    assign desc.lost     = lost_reg;
    assign desc.failsafe = failsafe_reg;

endmodule

>>> hw/rtl/sbfr_desc_fifo.sv
// Two-entry queue of frame descriptors between front and back.
// Depends on sbfr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbfr_desc_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sbfr_pkg::desc_t wdata,
    input  logic            pop,
    output sbfr_pkg::desc_t rdata,
    output logic            full,
    output logic            empty
);

    sbfr_pkg::desc_t entry_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign rdata = entry_reg[rd_ptr_reg];

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

    `ASSERT_NEVER(a_no_push_when_full, clk, rst_n, push && full)
    `ASSERT_NEVER(a_no_pop_when_empty, clk, rst_n, pop && empty)

endmodule

>>> hw/rtl/sbfr_back.sv
// Back of the sbus frame receiver: frame buffer, bit unpacker, result register.
// Depends on sbfr_pkg and assert_macros.svh; fed by sbfr_front via sbfr_desc_fifo.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbfr_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sbfr_pkg::ram_wr_t              ram_wr,
    input  logic                           desc_valid,
    input  sbfr_pkg::desc_t                desc,
    output logic                           desc_pop,
    input  logic                           pop,
    output logic                           empty,
    output logic [sbfr_pkg::CH_W-1:0]      channel_index,
    output logic [sbfr_pkg::VAL_W-1:0]     channel_value,
    output logic                           lost_frame,
    output logic                           failsafe_active,
    output logic                           last_of_frame
);

    logic [sbfr_pkg::BYTE_W-1:0] frame_ram [sbfr_pkg::RAM_DEPTH];

    sbfr_pkg::back_state_t           state_reg, state_next;
    logic                            bank_reg;
    logic [sbfr_pkg::POS_W-1:0]      rd_idx_reg;
    logic                            rd_pending_reg;
    logic [sbfr_pkg::BYTE_W-1:0]     rd_data_reg;
    logic [sbfr_pkg::ACC_W-1:0]      acc_reg, acc_next;
    logic [sbfr_pkg::ACC_CNT_W-1:0]  acc_cnt_reg, acc_cnt_next;
    logic [sbfr_pkg::CH_W-1:0]       chan_reg;
    logic                            out_valid_reg;
    logic                            take;
    logic                            out_free;
    logic                            emit;
    logic                            issue;
    logic                            start;
    logic                            done;

    // frame buffer, two banks of payload bytes
    always_ff @(posedge clk)
    begin
        if (ram_wr.en)
            frame_ram[ram_wr.addr] <= ram_wr.data;
        if (issue)
            rd_data_reg <= frame_ram[{bank_reg, rd_idx_reg}];
    end

    // handshake and unpack control
    assign take     = pop && out_valid_reg;
    assign out_free = !out_valid_reg || take;
    assign emit     = (state_reg == sbfr_pkg::BK_RUN)
                      && (acc_cnt_reg >= sbfr_pkg::VAL_BITS) && out_free;
    assign issue    = (state_reg == sbfr_pkg::BK_RUN) && !rd_pending_reg
                      && (acc_cnt_reg < sbfr_pkg::VAL_BITS)
                      && (rd_idx_reg <= sbfr_pkg::PAYLOAD_LAST);
    assign done     = emit && (chan_reg == sbfr_pkg::LAST_CHANNEL);
    assign start    = (state_reg == sbfr_pkg::BK_IDLE) && desc_valid;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sbfr_pkg::BK_IDLE: if (desc_valid) state_next = sbfr_pkg::BK_RUN;
            sbfr_pkg::BK_RUN:  if (done)       state_next = sbfr_pkg::BK_IDLE;
            default:                           state_next = sbfr_pkg::BK_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        unique case (state_reg)
            sbfr_pkg::BK_RUN: desc_pop = done;
            default:          desc_pop = 1'b0;
        endcase
    end

    // bit accumulator: bytes enter at the top, 11-bit values leave at the bottom
    always_comb
    begin
        acc_next     = acc_reg;
        acc_cnt_next = acc_cnt_reg;
        if (start)
        begin
            acc_next     = '0;
            acc_cnt_next = '0;
        end
        else if (rd_pending_reg)
        begin
            acc_next     = acc_reg
                           | (sbfr_pkg::ACC_W'(rd_data_reg) << acc_cnt_reg);
            acc_cnt_next = acc_cnt_reg + sbfr_pkg::BYTE_BITS;
        end
        else if (emit)
        begin
            acc_next     = acc_reg >> sbfr_pkg::VAL_W;
            acc_cnt_next = acc_cnt_reg - sbfr_pkg::VAL_BITS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sbfr_pkg::BK_IDLE;
            bank_reg       <= 1'b0;
            rd_idx_reg     <= sbfr_pkg::PAYLOAD_FIRST;
            rd_pending_reg <= 1'b0;
            acc_reg        <= '0;
            acc_cnt_reg    <= '0;
            chan_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_pending_reg <= issue;
            acc_reg        <= acc_next;
            acc_cnt_reg    <= acc_cnt_next;
            if (done)
                bank_reg <= !bank_reg;
            if (start)
                rd_idx_reg <= sbfr_pkg::PAYLOAD_FIRST;
            else if (issue)
                rd_idx_reg <= rd_idx_reg + 5'd1;
            if (start)
                chan_reg <= '0;
            else if (emit)
                chan_reg <= chan_reg + 4'd1;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (take)
                out_valid_reg <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            channel_index   <= chan_reg;
            channel_value   <= acc_reg[sbfr_pkg::VAL_W-1:0];
            lost_frame      <= desc.lost;
            failsafe_active <= desc.failsafe;
            last_of_frame   <= (chan_reg == sbfr_pkg::LAST_CHANNEL);
        end
    end

    assign empty = !out_valid_reg;

    // a fetched byte always fits into the accumulator
    `ASSERT_ON(a_acc_room, clk, rst_n, rd_pending_reg |-> (acc_cnt_reg < sbfr_pkg::VAL_BITS))
    // the last channel consumes exactly the last payload bit
    `ASSERT_ON(a_frame_drained, clk, rst_n,
        desc_pop |-> ((acc_cnt_reg == sbfr_pkg::VAL_BITS) && !rd_pending_reg
                      && (rd_idx_reg == sbfr_pkg::FLAGS_POS)))

endmodule

>>> hw/rtl/sbus_frame_receiver.sv
// sbus frame receiver: 16-channel S.Bus frame decoder.
// Input channel: push/full with rx_byte; one byte is taken in any cycle in
//   which push is high and full is low.
// Result channel: empty/pop; while empty is low the oldest channel result is
//   on channel_index, channel_value, lost_frame, failsafe_active and
//   last_of_frame, and pop takes it.
// Configuration: cfg_wr_en writes cfg_wdata to start marker (index 0) or end
//   marker (index 1) in the same cycle; write only while the block is idle.
// Throughput: one byte per cycle at the input while full is low. A valid
//   frame is unpacked by a bit accumulator fed one buffer byte at a time into
//   its 16 results.
// Two frame buffer banks and a two-entry queue let a new frame be collected
//   while the previous one drains; full is high while two decoded frames are
//   held. At one byte per cycle that happens even with an eager receiver.
// Reset: markers return to 0x0F and 0x00, sync is lost, queues are emptied.
// A stalled receiver holds the current result; bytes keep flowing until the
//   queue fills.
// Depends on sbfr_pkg, sbfr_front, sbfr_desc_fifo, sbfr_back.
`timescale 1ns / 1ps

module sbus_frame_receiver (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [sbfr_pkg::BYTE_W-1:0]      rx_byte,
    output logic                             empty,
    input  logic                             pop,
    output logic [sbfr_pkg::CH_W-1:0]        channel_index,
    output logic [sbfr_pkg::VAL_W-1:0]       channel_value,
    output logic                             lost_frame,
    output logic                             failsafe_active,
    output logic                             last_of_frame,
    input  logic                             cfg_wr_en,
    input  logic [sbfr_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [sbfr_pkg::BYTE_W-1:0]      cfg_wdata
);

    sbfr_pkg::ram_wr_t ram_wr;
    sbfr_pkg::desc_t   push_desc;
    sbfr_pkg::desc_t   head_desc;
    logic              desc_push;
    logic              desc_pop;
    logic              desc_empty;

    // byte collection and frame check
    sbfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .rx_byte   (rx_byte),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .ram_wr    (ram_wr),
        .desc_push (desc_push),
        .desc      (push_desc)
    );

    // decoded frames waiting for unpack
    sbfr_desc_fifo u_desc_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (desc_push),
        .wdata (push_desc),
        .pop   (desc_pop),
        .rdata (head_desc),
        .full  (full),
        .empty (desc_empty)
    );

    // channel unpack and result register
    sbfr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .ram_wr          (ram_wr),
        .desc_valid      (!desc_empty),
        .desc            (head_desc),
        .desc_pop        (desc_pop),
        .pop             (pop),
        .empty           (empty),
        .channel_index   (channel_index),
        .channel_value   (channel_value),
        .lost_frame      (lost_frame),
        .failsafe_active (failsafe_active),
        .last_of_frame   (last_of_frame)
    );

endmodule
